>>> rtl/hbw_pkg.sv
// Shared types, constants and helper functions of the heartbeat watchdog.
package hbw_pkg;

	// Sizing
	localparam int MAX_CPUS = 8;
	localparam int CPU_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int CNT_W    = $clog2(MAX_CPUS + 1);
	localparam int MASK_W   = 8;
	localparam int CTR_W    = 32;
	localparam int TPS_W    = 16;
	localparam int TMO_W    = 8;
	localparam int LIM_W    = TPS_W + TMO_W;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = TPS_W;

	// Reset and default register values
	localparam logic [TPS_W-1:0] TPS_RESET  = TPS_W'(100);
	localparam logic [TPS_W-1:0] HZ_DEFAULT = TPS_W'(100);
	localparam logic [TMO_W-1:0] TMO_RESET  = TMO_W'(5);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TPS = 1'b0,
		REG_TMO = 1'b1
	} cfg_reg_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_HB_UPD = 4'b0010,
		S_WALK   = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	// Per-CPU watchdog entry held in memory
	typedef struct packed {
		logic [CTR_W-1:0] observed;
		logic [CTR_W-1:0] progress;
		logic             reported;
	} pcpu_entry_t;

	localparam int ENTRY_W = $bits(pcpu_entry_t);

	// Outcome of checking one CPU
	typedef struct packed {
		logic        wr;
		pcpu_entry_t entry;
		logic        clr_stall;
		logic        set_stall;
		logic        fresh;
	} chk_res_t;

	// Clamp the raw CPU count into 1..MAX_CPUS
	function automatic logic [CNT_W-1:0] clamp_count(input logic [7:0] raw);
		logic [CNT_W-1:0] n;
		if (raw == 8'd0) begin
			n = CNT_W'(1);
		end else if (32'(raw) > 32'(MAX_CPUS)) begin
			n = CNT_W'(MAX_CPUS);
		end else begin
			n = CNT_W'(raw);
		end
		return n;
	endfunction

	// One-hot mask bit for a CPU; zero for CPUs beyond the mask width
	function automatic logic [MASK_W-1:0] cpu_bit(input logic [CPU_W-1:0] cpu);
		logic [7:0] c8;
		c8 = 8'(cpu);
		return MASK_W'(1) << c8;
	endfunction

endpackage

>>> rtl/hbw_in_if.sv
// Input channel: heartbeat or timer tick transaction.
interface hbw_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] cpu_index;
	logic       scheduler_started;
	logic [7:0] cpu_count;
	logic [7:0] online_mask;

	modport source (
		output valid, mode, cpu_index, scheduler_started, cpu_count, online_mask,
		input  ready
	);
	modport sink (
		input  valid, mode, cpu_index, scheduler_started, cpu_count, online_mask,
		output ready
	);
endinterface

>>> rtl/hbw_out_if.sv
// Output channel: watchdog status transaction.
interface hbw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] stalled_mask;
	logic [7:0] new_report_mask;
	logic       armed;

	modport source (
		output valid, stalled_mask, new_report_mask, armed,
		input  ready
	);
	modport sink (
		input  valid, stalled_mask, new_report_mask, armed,
		output ready
	);
endinterface

>>> rtl/hbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hbw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/hbw_chk.sv
// Per-CPU evaluation: snapshot on arming, progress and timeout check when armed.
module hbw_chk (
	input  logic                      arm,
	input  logic                      online,
	input  logic [hbw_pkg::CTR_W-1:0] hb,
	input  hbw_pkg::pcpu_entry_t      entry,
	input  logic [hbw_pkg::CTR_W-1:0] now,
	input  logic [hbw_pkg::CTR_W-1:0] limit,
	output hbw_pkg::chk_res_t         res
);
	logic [hbw_pkg::CTR_W-1:0] idle_ticks;

	assign idle_ticks = now - entry.progress;

	always_comb begin
		res                = '0;
		res.entry          = entry;
		if (arm) begin
			// snapshot on arming
			res.wr             = 1'b1;
			res.entry.observed = hb;
			res.entry.progress = now;
			res.entry.reported = 1'b0;
		end else if (!online) begin
			res.wr = 1'b0;
		end else if (hb != entry.observed) begin
			// progress seen: refresh and clear stall
			res.wr             = 1'b1;
			res.entry.observed = hb;
			res.entry.progress = now;
			res.entry.reported = 1'b0;
			res.clr_stall      = 1'b1;
		end else if (idle_ticks >= limit) begin
			// timed out: stall, report once
			res.set_stall = 1'b1;
			if (!entry.reported) begin
				res.wr             = 1'b1;
				res.entry.reported = 1'b1;
				res.fresh          = 1'b1;
			end
		end
	end
endmodule

>>> rtl/multicore_heartbeat_watchdog.sv
// Top level of the multicore heartbeat watchdog: controller, memories and output register.
//
//  Channel  Dir  Handshake      Transaction
//  item     in   valid/ready    heartbeat (mode=1) or timer tick (mode=0)
//  result   out  valid/ready    stalled_mask, new_report_mask, armed
//  cfg      in   cfg_we only    cfg_index selects ticks_per_second / timeout_seconds
//
// Heartbeat: accept, counter memory read-modify-write, output load.
// Tick that polls or arms: walks the CPU table, one entry read per cycle
// with each update written back in the cycle after its read; other ticks skip the walk.
// Reset clears control state and the per-entry valid bits; unwritten entries read as zero.
// A new transaction is taken while the previous result waits on result.ready.
module multicore_heartbeat_watchdog (
	input  logic                          clk,
	input  logic                          arst_n,
	hbw_in_if.sink                        item,
	hbw_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [hbw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hbw_pkg::CFG_DATA_W-1:0] cfg_data
);
	hbw_pkg::state_t state_q;

	// Configuration registers
	logic [hbw_pkg::TPS_W-1:0] tps_q;
	logic [hbw_pkg::TMO_W-1:0] tmo_q;
	logic [hbw_pkg::TPS_W-1:0] hz;

	// Global watchdog state
	logic [hbw_pkg::CTR_W-1:0]  tick_now_q;
	logic [hbw_pkg::CTR_W-1:0]  last_poll_q;
	logic [hbw_pkg::MASK_W-1:0] stall_q;
	logic                       armed_q;

	// Per-transaction work registers
	logic [hbw_pkg::MASK_W-1:0] fresh_q;
	logic [hbw_pkg::MASK_W-1:0] online_q;
	logic [hbw_pkg::CNT_W-1:0]  cnt_q;
	logic [hbw_pkg::CNT_W-1:0]  issue_q;
	logic                       arm_walk_q;
	logic [hbw_pkg::CTR_W-1:0]  limit_q;
	logic [hbw_pkg::CPU_W-1:0]  cpu_s1;
	logic                       vld_s1;

	// Entry valid bits
	logic [hbw_pkg::MAX_CPUS-1:0] hb_vld_q;
	logic [hbw_pkg::MAX_CPUS-1:0] pc_vld_q;

	// Output register
	logic                       res_vld_q;
	logic [hbw_pkg::MASK_W-1:0] res_stall_q;
	logic [hbw_pkg::MASK_W-1:0] res_fresh_q;
	logic                       res_armed_q;

	// Memory ports
	logic [hbw_pkg::CPU_W-1:0]   raddr;
	logic [hbw_pkg::CTR_W-1:0]   hb_rdata;
	logic [hbw_pkg::CTR_W-1:0]   hb_val;
	logic                        hb_we;
	logic [hbw_pkg::CTR_W-1:0]   hb_wdata;
	logic [hbw_pkg::ENTRY_W-1:0] pc_rdata;
	hbw_pkg::pcpu_entry_t        pc_val;
	logic                        pc_we;

	logic                        accept;
	logic [hbw_pkg::CPU_W-1:0]   hb_cpu;
	logic [hbw_pkg::CTR_W-1:0]   now_n;
	logic [hbw_pkg::CTR_W-1:0]   since_poll;
	logic                        issue_more;
	logic                        out_free;
	logic [hbw_pkg::MASK_W-1:0]  bit_s1;
	hbw_pkg::chk_res_t           chk;

	assign accept     = item.valid && item.ready;
	assign item.ready = (state_q == hbw_pkg::S_IDLE);
	assign hz         = (tps_q == '0) ? hbw_pkg::HZ_DEFAULT : tps_q;
	assign now_n      = tick_now_q + hbw_pkg::CTR_W'(1);
	assign since_poll = now_n - last_poll_q;
	assign issue_more = (issue_q < cnt_q);
	assign out_free   = !res_vld_q || result.ready;
	assign bit_s1     = hbw_pkg::cpu_bit(cpu_s1);

	// Out-of-range heartbeat index counts for CPU 0
	assign hb_cpu = (32'(item.cpu_index) >= 32'(hbw_pkg::MAX_CPUS)) ? '0 :
		hbw_pkg::CPU_W'(item.cpu_index);

	// Read address: heartbeat target at accept, table walk otherwise
	assign raddr = (state_q == hbw_pkg::S_IDLE) ? hb_cpu : issue_q[hbw_pkg::CPU_W-1:0];

	// Entries never written read as zero
	assign hb_val = hb_vld_q[cpu_s1] ? hb_rdata : '0;
	assign pc_val = pc_vld_q[cpu_s1] ? hbw_pkg::pcpu_entry_t'(pc_rdata) : '0;

	// Memory writes
	assign hb_we    = (state_q == hbw_pkg::S_HB_UPD);
	assign hb_wdata = hb_val + hbw_pkg::CTR_W'(1);
	assign pc_we    = (state_q == hbw_pkg::S_WALK) && vld_s1 && chk.wr;

	hbw_ram #(
		.WIDTH(hbw_pkg::CTR_W),
		.DEPTH(hbw_pkg::MAX_CPUS)
	) u_hb_ram (
		.clk   (clk),
		.we    (hb_we),
		.waddr (cpu_s1),
		.wdata (hb_wdata),
		.raddr (raddr),
		.rdata (hb_rdata)
	);

	hbw_ram #(
		.WIDTH(hbw_pkg::ENTRY_W),
		.DEPTH(hbw_pkg::MAX_CPUS)
	) u_pc_ram (
		.clk   (clk),
		.we    (pc_we),
		.waddr (cpu_s1),
		.wdata (chk.entry),
		.raddr (raddr),
		.rdata (pc_rdata)
	);

	hbw_chk u_chk (
		.arm    (arm_walk_q),
		.online (|(online_q & bit_s1)),
		.hb     (hb_val),
		.entry  (pc_val),
		.now    (tick_now_q),
		.limit  (limit_q),
		.res    (chk)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= hbw_pkg::TPS_RESET;
			tmo_q <= hbw_pkg::TMO_RESET;
		end else if (cfg_we) begin
			case (hbw_pkg::cfg_reg_t'(cfg_index))
				hbw_pkg::REG_TPS: tps_q <= cfg_data;
				hbw_pkg::REG_TMO: tmo_q <= hbw_pkg::TMO_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// Payload work registers; timeout in ticks needs the full product width
	always_ff @(posedge clk) begin
		if (accept) begin
			online_q   <= item.online_mask;
			cnt_q      <= hbw_pkg::clamp_count(item.cpu_count);
			limit_q    <= hbw_pkg::CTR_W'(hbw_pkg::LIM_W'(hz) * hbw_pkg::LIM_W'(tmo_q));
			arm_walk_q <= !armed_q;
		end
	end

	// Controller, global state and table walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbw_pkg::S_IDLE;
			tick_now_q  <= '0;
			last_poll_q <= '0;
			stall_q     <= '0;
			armed_q     <= 1'b0;
			fresh_q     <= '0;
			issue_q     <= '0;
			cpu_s1      <= '0;
			vld_s1      <= 1'b0;
			hb_vld_q    <= '0;
			pc_vld_q    <= '0;
		end else begin
			case (state_q)
				hbw_pkg::S_IDLE: begin
					issue_q <= '0;
					vld_s1  <= 1'b0;
					fresh_q <= '0;
					if (accept) begin
						if (item.mode) begin
							cpu_s1  <= hb_cpu;
							state_q <= hbw_pkg::S_HB_UPD;
						end else begin
							tick_now_q <= now_n;
							if (!item.scheduler_started) begin
								last_poll_q <= now_n;
								armed_q     <= 1'b0;
								stall_q     <= '0;
								state_q     <= hbw_pkg::S_DONE;
							end else if (!armed_q) begin
								last_poll_q <= now_n;
								armed_q     <= 1'b1;
								stall_q     <= '0;
								state_q     <= hbw_pkg::S_WALK;
							end else if (since_poll < hbw_pkg::CTR_W'(hz)) begin
								state_q <= hbw_pkg::S_DONE;
							end else begin
								last_poll_q <= now_n;
								state_q     <= hbw_pkg::S_WALK;
							end
						end
					end
				end
				hbw_pkg::S_HB_UPD: begin
					hb_vld_q[cpu_s1] <= 1'b1;
					state_q          <= hbw_pkg::S_DONE;
				end
				hbw_pkg::S_WALK: begin
					// apply the check of the entry read last cycle
					if (vld_s1) begin
						if (chk.wr) begin
							pc_vld_q[cpu_s1] <= 1'b1;
						end
						stall_q <= (stall_q & ~(chk.clr_stall ? bit_s1 : '0)) |
							(chk.set_stall ? bit_s1 : '0);
						fresh_q <= fresh_q | (chk.fresh ? bit_s1 : '0);
					end
					// issue the next entry read
					if (issue_more) begin
						cpu_s1  <= issue_q[hbw_pkg::CPU_W-1:0];
						vld_s1  <= 1'b1;
						issue_q <= issue_q + hbw_pkg::CNT_W'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= hbw_pkg::S_DONE;
						end
					end
				end
				hbw_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= hbw_pkg::S_IDLE;
					end
				end
				default: state_q <= hbw_pkg::S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if ((state_q == hbw_pkg::S_DONE) && out_free) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == hbw_pkg::S_DONE) && out_free) begin
			res_stall_q <= stall_q;
			res_fresh_q <= fresh_q;
			res_armed_q <= armed_q;
		end
	end

	assign result.valid           = res_vld_q;
	assign result.stalled_mask    = res_stall_q;
	assign result.new_report_mask = res_fresh_q;
	assign result.armed           = res_armed_q;
endmodule
